[src/baro_pressure_temp_compensation_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the barometer compensation block
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// same-cycle implication
`define BPTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bptc_pkg.sv]
// ----------------------------------------------------------------------------
// bptc_pkg
// Widths, limits and register indexes for the barometer compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package bptc_pkg;

    localparam int RAW_W   = 24;   // raw conversion
    localparam int CAL_W   = 16;   // calibration word
    localparam int IDX_W   = 3;    // register index
    localparam int TOUT_W  = 15;   // temperature result
    localparam int POUT_W  = 17;   // pressure result
    localparam int NSTAGE  = 10;   // pipeline depth

    localparam int DT_W    = 25;   // dT, signed
    localparam int MUL_W   = 42;   // dT times a calibration word
    localparam int SQ_W    = 50;   // dT squared
    localparam int TEMP_W  = 20;   // temperature intermediates, signed
    localparam int T2_W    = 18;   // T2, unsigned
    localparam int SQR_W   = 36;   // squares of the temperature deltas
    localparam int CORR_W  = 40;   // OFF2 / SENS2, unsigned
    localparam int OFF_W   = 42;   // OFF, signed
    localparam int SENS_W  = 41;   // SENS, signed
    localparam int LO_W    = 21;   // low slice of SENS for the split product
    localparam int PP_W    = 46;   // partial products
    localparam int PROD_W  = 64;   // D1 * SENS
    localparam int DIFF_W  = 44;   // (D1*SENS >> 21) - OFF
    localparam int PRES_W  = 29;   // pressure before saturation

    localparam int TEMP_REF   = 2000;
    localparam int COLD_EDGE  = 3500;   // 2000 + 1500
    localparam int TEMP_MIN   = -4000;
    localparam int TEMP_MAX   = 8500;
    localparam int PRES_MIN   = 1000;
    localparam int PRES_MAX   = 120000;

    localparam logic [IDX_W-1:0] IDX_C1 = 3'd0;
    localparam logic [IDX_W-1:0] IDX_C2 = 3'd1;
    localparam logic [IDX_W-1:0] IDX_C3 = 3'd2;
    localparam logic [IDX_W-1:0] IDX_C4 = 3'd3;
    localparam logic [IDX_W-1:0] IDX_C5 = 3'd4;
    localparam logic [IDX_W-1:0] IDX_C6 = 3'd5;

endpackage

`default_nettype wire

[src/baro_pressure_temp_compensation.sv]
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Each accepted request moves through the 10 registered stages to out_valid.
// Throughput: one request per cycle while out_ready is high; each of the 10
// stages holds or moves on its own, so bubbles close up under output back-pressure.
// Reset: calibration words clear to zero and the pipeline empties.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_pressure_temp_compensation
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 wr_en,
    input  wire logic [bptc_pkg::IDX_W-1:0]           wr_index,
    input  wire logic [bptc_pkg::CAL_W-1:0]           wr_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [bptc_pkg::RAW_W-1:0]           raw_pressure,
    input  wire logic [bptc_pkg::RAW_W-1:0]           raw_temperature,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [bptc_pkg::TOUT_W-1:0]        temp_hundredths,
    output logic [bptc_pkg::POUT_W-1:0]               pressure_pascal,
    output logic                                      clamped
);

    localparam int N = bptc_pkg::NSTAGE;

    // calibration words
    logic [bptc_pkg::CAL_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    logic [N-1:0] v_reg;
    logic [N-1:0] adv;

    // stage 1
    logic signed [bptc_pkg::DT_W-1:0]   dt1_reg, dt1_next;
    logic [bptc_pkg::RAW_W-1:0]         d1_1_reg;
    // stage 2
    logic signed [bptc_pkg::MUL_W-1:0]  pt2_reg, po2_reg, ps2_reg;
    logic signed [bptc_pkg::MUL_W-1:0]  pt2_next, po2_next, ps2_next;
    logic signed [bptc_pkg::SQ_W-1:0]   sq2_reg, sq2_next;
    logic [bptc_pkg::RAW_W-1:0]         d1_2_reg;
    // stage 3
    logic signed [bptc_pkg::TEMP_W-1:0] x3_reg, x3_next, e3_reg, e3_next;
    logic signed [bptc_pkg::OFF_W-1:0]  off3_reg, off3_next;
    logic signed [bptc_pkg::SENS_W-1:0] sens3_reg, sens3_next;
    logic [bptc_pkg::T2_W-1:0]          t2_3_reg;
    logic [bptc_pkg::RAW_W-1:0]         d1_3_reg;
    // stage 4
    logic signed [bptc_pkg::TEMP_W-1:0] temp4_reg, temp4_next;
    logic signed [2*bptc_pkg::TEMP_W-1:0] dsq_full, esq_full;
    logic [bptc_pkg::SQR_W-1:0]         dsq4_reg, esq4_reg;
    logic                               cold4_reg, frigid4_reg;
    logic signed [bptc_pkg::OFF_W-1:0]  off4_reg;
    logic signed [bptc_pkg::SENS_W-1:0] sens4_reg;
    logic [bptc_pkg::RAW_W-1:0]         d1_4_reg;
    // stage 5
    logic [bptc_pkg::OFF_W-1:0]         dsq61;
    logic [bptc_pkg::CORR_W-1:0]        off2_5_reg, off2_next, sens2_5_reg, sens2_next;
    logic signed [bptc_pkg::TEMP_W-1:0] temp5_reg;
    logic signed [bptc_pkg::OFF_W-1:0]  off5_reg;
    logic signed [bptc_pkg::SENS_W-1:0] sens5_reg;
    logic [bptc_pkg::RAW_W-1:0]         d1_5_reg;
    // stage 6
    logic signed [bptc_pkg::OFF_W-1:0]  off6_reg, off6_next;
    logic signed [bptc_pkg::SENS_W-1:0] sens6_reg, sens6_next;
    logic signed [bptc_pkg::TOUT_W-1:0] tout6_reg, tout6_next;
    logic                               tclamp6_reg, tclamp6_next;
    logic [bptc_pkg::RAW_W-1:0]         d1_6_reg;
    // stage 7
    logic [bptc_pkg::PP_W-1:0]          pl7_reg, pl7_next;
    logic signed [bptc_pkg::PP_W-1:0]   ph7_reg, ph7_next;
    logic signed [bptc_pkg::OFF_W-1:0]  off7_reg;
    logic signed [bptc_pkg::TOUT_W-1:0] tout7_reg;
    logic                               tclamp7_reg;
    // stage 8
    logic signed [bptc_pkg::PROD_W-1:0] prod8_reg, prod8_next;
    logic signed [bptc_pkg::OFF_W-1:0]  off8_reg;
    logic signed [bptc_pkg::TOUT_W-1:0] tout8_reg;
    logic                               tclamp8_reg;
    // stage 9
    logic signed [bptc_pkg::DIFF_W-1:0] diff9_reg, diff9_next;
    logic signed [bptc_pkg::TOUT_W-1:0] tout9_reg;
    logic                               tclamp9_reg;
    // stage 10
    logic signed [bptc_pkg::PRES_W-1:0] pres_full;
    logic [bptc_pkg::POUT_W-1:0]        pout_reg, pout_next;
    logic signed [bptc_pkg::TOUT_W-1:0] tout_reg;
    logic                               clamp_reg, clamp_next;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                bptc_pkg::IDX_C1: c1_reg <= wr_data;
                bptc_pkg::IDX_C2: c2_reg <= wr_data;
                bptc_pkg::IDX_C3: c3_reg <= wr_data;
                bptc_pkg::IDX_C4: c4_reg <= wr_data;
                bptc_pkg::IDX_C5: c5_reg <= wr_data;
                bptc_pkg::IDX_C6: c6_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage flow: a stage moves when it is empty or the next one moves
    // ------------------------------------------------------------------
    always_comb
    begin
        adv[N-1] = !v_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
    end

    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < N; k++)
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        // 1: dT = D2 - C5*256
        dt1_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, c5_reg, 8'd0});

        // 2: products with dT
        pt2_next = dt1_reg * $signed({1'b0, c6_reg});
        po2_next = dt1_reg * $signed({1'b0, c4_reg});
        ps2_next = dt1_reg * $signed({1'b0, c3_reg});
        sq2_next = dt1_reg * dt1_reg;

        // 3: x = TEMP - 2000, e = TEMP + 1500
        x3_next    = bptc_pkg::TEMP_W'(pt2_reg >>> 23);
        e3_next    = bptc_pkg::TEMP_W'(pt2_reg >>> 23)
                     + bptc_pkg::TEMP_W'(bptc_pkg::COLD_EDGE);
        off3_next  = bptc_pkg::OFF_W'($signed({1'b0, c2_reg, 17'd0})) + (po2_reg >>> 6);
        sens3_next = bptc_pkg::SENS_W'($signed({1'b0, c1_reg, 16'd0}))
                     + bptc_pkg::SENS_W'(ps2_reg >>> 7);

        // 4: squares, first-order temperature minus T2
        dsq_full   = x3_reg * x3_reg;
        esq_full   = e3_reg * e3_reg;
        temp4_next = x3_reg + bptc_pkg::TEMP_W'(bptc_pkg::TEMP_REF)
                     - ((x3_reg < 0) ? $signed({2'b00, t2_3_reg})
                                     : bptc_pkg::TEMP_W'(0));

        // 5: OFF2 and SENS2; squares are never negative
        dsq61      = bptc_pkg::OFF_W'(dsq4_reg) * bptc_pkg::OFF_W'(61);
        off2_next  = '0;
        sens2_next = '0;
        if (cold4_reg)
        begin
            off2_next  = bptc_pkg::CORR_W'(dsq61 >> 4);
            sens2_next = bptc_pkg::CORR_W'({dsq4_reg, 1'b0});
            if (frigid4_reg)
            begin
                off2_next  = off2_next
                             + bptc_pkg::CORR_W'(esq4_reg) * bptc_pkg::CORR_W'(15);
                sens2_next = sens2_next + bptc_pkg::CORR_W'({esq4_reg, 3'd0});
            end
        end

        // 6: final OFF, SENS; temperature saturation
        off6_next  = off5_reg - $signed({2'b00, off2_5_reg});
        sens6_next = sens5_reg - $signed({1'b0, sens2_5_reg});
        tclamp6_next = 1'b0;
        tout6_next   = bptc_pkg::TOUT_W'(temp5_reg);
        if (temp5_reg < bptc_pkg::TEMP_MIN)
        begin
            tout6_next   = bptc_pkg::TOUT_W'(bptc_pkg::TEMP_MIN);
            tclamp6_next = 1'b1;
        end
        else if (temp5_reg > bptc_pkg::TEMP_MAX)
        begin
            tout6_next   = bptc_pkg::TOUT_W'(bptc_pkg::TEMP_MAX);
            tclamp6_next = 1'b1;
        end

        // 7: D1 * SENS as two partial products (signed high slice)
        pl7_next = bptc_pkg::PP_W'(d1_6_reg) * bptc_pkg::PP_W'(sens6_reg[bptc_pkg::LO_W-1:0]);
        ph7_next = $signed({1'b0, d1_6_reg})
                   * $signed(sens6_reg[bptc_pkg::SENS_W-1:bptc_pkg::LO_W]);

        // 8: recombine
        prod8_next = (bptc_pkg::PROD_W'(ph7_reg) <<< bptc_pkg::LO_W)
                     + bptc_pkg::PROD_W'(pl7_reg);

        // 9
        diff9_next = bptc_pkg::DIFF_W'(prod8_reg >>> 21) - bptc_pkg::DIFF_W'(off8_reg);

        // 10: pressure and saturation
        pres_full  = bptc_pkg::PRES_W'(diff9_reg >>> 15);
        clamp_next = tclamp9_reg;
        pout_next  = bptc_pkg::POUT_W'(pres_full);
        if (pres_full < bptc_pkg::PRES_MIN)
        begin
            pout_next  = bptc_pkg::POUT_W'(bptc_pkg::PRES_MIN);
            clamp_next = 1'b1;
        end
        else if (pres_full > bptc_pkg::PRES_MAX)
        begin
            pout_next  = bptc_pkg::POUT_W'(bptc_pkg::PRES_MAX);
            clamp_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dt1_reg  <= dt1_next;
            d1_1_reg <= raw_pressure;
        end
        if (adv[1])
        begin
            pt2_reg  <= pt2_next;
            po2_reg  <= po2_next;
            ps2_reg  <= ps2_next;
            sq2_reg  <= sq2_next;
            d1_2_reg <= d1_1_reg;
        end
        if (adv[2])
        begin
            x3_reg    <= x3_next;
            e3_reg    <= e3_next;
            off3_reg  <= off3_next;
            sens3_reg <= sens3_next;
            t2_3_reg  <= sq2_reg[bptc_pkg::T2_W+30:31];   // dT^2 >> 31, never negative
            d1_3_reg  <= d1_2_reg;
        end
        if (adv[3])
        begin
            temp4_reg   <= temp4_next;
            dsq4_reg    <= dsq_full[bptc_pkg::SQR_W-1:0];
            esq4_reg    <= esq_full[bptc_pkg::SQR_W-1:0];
            cold4_reg   <= (x3_reg < 0);
            frigid4_reg <= (e3_reg < 0);
            off4_reg    <= off3_reg;
            sens4_reg   <= sens3_reg;
            d1_4_reg    <= d1_3_reg;
        end
        if (adv[4])
        begin
            off2_5_reg  <= off2_next;
            sens2_5_reg <= sens2_next;
            temp5_reg   <= temp4_reg;
            off5_reg    <= off4_reg;
            sens5_reg   <= sens4_reg;
            d1_5_reg    <= d1_4_reg;
        end
        if (adv[5])
        begin
            off6_reg    <= off6_next;
            sens6_reg   <= sens6_next;
            tout6_reg   <= tout6_next;
            tclamp6_reg <= tclamp6_next;
            d1_6_reg    <= d1_5_reg;
        end
        if (adv[6])
        begin
            pl7_reg     <= pl7_next;
            ph7_reg     <= ph7_next;
            off7_reg    <= off6_reg;
            tout7_reg   <= tout6_reg;
            tclamp7_reg <= tclamp6_reg;
        end
        if (adv[7])
        begin
            prod8_reg   <= prod8_next;
            off8_reg    <= off7_reg;
            tout8_reg   <= tout7_reg;
            tclamp8_reg <= tclamp7_reg;
        end
        if (adv[8])
        begin
            diff9_reg   <= diff9_next;
            tout9_reg   <= tout8_reg;
            tclamp9_reg <= tclamp8_reg;
        end
        if (adv[9])
        begin
            pout_reg  <= pout_next;
            tout_reg  <= tout9_reg;
            clamp_reg <= clamp_next;
        end
    end

    assign out_valid       = v_reg[N-1];
    assign temp_hundredths = tout_reg;
    assign pressure_pascal = pout_reg;
    assign clamped         = clamp_reg;

endmodule

`default_nettype wire

[src/bptc_checker.sv]
// ----------------------------------------------------------------------------
// bptc_checker
// Port-level checks on the barometer compensation block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "baro_pressure_temp_compensation_assert.svh"

module bptc_checker
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_ready,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_ready,
    input  wire logic signed [bptc_pkg::TOUT_W-1:0]   temp_hundredths,
    input  wire logic [bptc_pkg::POUT_W-1:0]          pressure_pascal,
    input  wire logic                                 clamped
);

    logic t_inside, p_inside;

    assign t_inside = (temp_hundredths > bptc_pkg::TEMP_MIN)
                   && (temp_hundredths < bptc_pkg::TEMP_MAX);
    assign p_inside = (pressure_pascal > bptc_pkg::PRES_MIN)
                   && (pressure_pascal < bptc_pkg::PRES_MAX);

    `BPTC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(temp_hundredths) && $stable(pressure_pascal) && $stable(clamped),
        "result changed while stalled")

    // the pipeline only refuses a request when it is full and blocked at the output
    `BPTC_ASSERT_IMP(a_full_stall, clk, rst_n, !in_ready,
        out_valid && !out_ready, "request refused with room in the pipeline")

    `BPTC_ASSERT_IMP(a_temp_range, clk, rst_n, out_valid,
        temp_hundredths >= bptc_pkg::TEMP_MIN && temp_hundredths <= bptc_pkg::TEMP_MAX,
        "temperature out of range")

    `BPTC_ASSERT_IMP(a_pres_range, clk, rst_n, out_valid,
        pressure_pascal >= bptc_pkg::PRES_MIN && pressure_pascal <= bptc_pkg::PRES_MAX,
        "pressure out of range")

    // a saturated value sits on a bound
    `BPTC_ASSERT_IMP(a_clamp_flag, clk, rst_n, out_valid && t_inside && p_inside,
        !clamped, "clamped set with both values strictly inside")

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .temp_hundredths (temp_hundredths),
    .pressure_pascal (pressure_pascal),
    .clamped         (clamped)
);

`default_nettype wire

[verif/baro_pressure_temp_compensation_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_test
// Self-checking bench for the barometer compensation pipeline. Loads sets of
// calibration words, sends raw D1/D2 pairs, predicts each compensated
// temperature/pressure pair with 64-bit integer math and checks every
// response in order. Both handshake sides idle at random.
// ----------------------------------------------------------------------------

module baro_pressure_temp_compensation_test;

    // register indexes past the last calibration word; writes there are dropped
    localparam logic [bptc_pkg::IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [bptc_pkg::IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    // typical factory calibration
    localparam int TYP_C1 = 46372;
    localparam int TYP_C2 = 43981;
    localparam int TYP_C3 = 29059;
    localparam int TYP_C4 = 27842;
    localparam int TYP_C5 = 31553;
    localparam int TYP_C6 = 28165;

    typedef struct packed {
        logic signed [bptc_pkg::TOUT_W-1:0] centi_deg;
        logic [bptc_pkg::POUT_W-1:0]        pascal;
        logic                               clamp;
    } reading_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               wr_en = 1'b0;
    logic [bptc_pkg::IDX_W-1:0]         wr_index = bptc_pkg::IDX_C1;
    logic [bptc_pkg::CAL_W-1:0]         wr_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [bptc_pkg::RAW_W-1:0]         raw_pressure = '0;
    logic [bptc_pkg::RAW_W-1:0]         raw_temperature = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic signed [bptc_pkg::TOUT_W-1:0] temp_hundredths;
    logic [bptc_pkg::POUT_W-1:0]        pressure_pascal;
    logic                               clamped;

    logic [bptc_pkg::CAL_W-1:0] cal_model [0:5] = '{default: '0};
    reading_t                   readings_due [$];
    int                         mismatch_count = 0;
    bit                         src_gaps = 1'b1;
    bit                         sink_stalls = 1'b1;
    int                         sink_hold = 0;

    baro_pressure_temp_compensation u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .raw_pressure    (raw_pressure),
        .raw_temperature (raw_temperature),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .temp_hundredths (temp_hundredths),
        .pressure_pascal (pressure_pascal),
        .clamped         (clamped)
    );

    always #1 clk = ~clk;

    // Second-order compensation, exact 64-bit; >>> on longint floors.
    function automatic reading_t compensate_reading(
        input logic [bptc_pkg::RAW_W-1:0] d1_raw,
        input logic [bptc_pkg::RAW_W-1:0] d2_raw);
        longint   d1, d2, c1, c2, c3, c4, c5, c6;
        longint   dt, t, off, sens, t2, off2, sens2, p, dw, dc;
        reading_t r;
        d1 = longint'(d1_raw);
        d2 = longint'(d2_raw);
        c1 = longint'(cal_model[bptc_pkg::IDX_C1]);
        c2 = longint'(cal_model[bptc_pkg::IDX_C2]);
        c3 = longint'(cal_model[bptc_pkg::IDX_C3]);
        c4 = longint'(cal_model[bptc_pkg::IDX_C4]);
        c5 = longint'(cal_model[bptc_pkg::IDX_C5]);
        c6 = longint'(cal_model[bptc_pkg::IDX_C6]);
        dt    = d2 - c5 * 256;
        t     = bptc_pkg::TEMP_REF + ((dt * c6) >>> 23);
        off   = c2 * 131072 + ((c4 * dt) >>> 6);
        sens  = c1 * 65536 + ((c3 * dt) >>> 7);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        if (t < bptc_pkg::TEMP_REF)
        begin
            dw    = t - bptc_pkg::TEMP_REF;
            t2    = (dt * dt) >>> 31;
            off2  = (61 * dw * dw) >>> 4;
            sens2 = 2 * dw * dw;
            // below -15.00 C
            if (t < bptc_pkg::TEMP_REF - bptc_pkg::COLD_EDGE)
            begin
                dc    = t - (bptc_pkg::TEMP_REF - bptc_pkg::COLD_EDGE);
                off2  = off2 + 15 * dc * dc;
                sens2 = sens2 + 8 * dc * dc;
            end
        end
        off  = off - off2;
        sens = sens - sens2;
        t    = t - t2;
        p    = (((d1 * sens) >>> 21) - off) >>> 15;
        r.clamp = 1'b0;
        if (t < bptc_pkg::TEMP_MIN)
        begin
            t = bptc_pkg::TEMP_MIN;
            r.clamp = 1'b1;
        end
        if (t > bptc_pkg::TEMP_MAX)
        begin
            t = bptc_pkg::TEMP_MAX;
            r.clamp = 1'b1;
        end
        if (p < bptc_pkg::PRES_MIN)
        begin
            p = bptc_pkg::PRES_MIN;
            r.clamp = 1'b1;
        end
        if (p > bptc_pkg::PRES_MAX)
        begin
            p = bptc_pkg::PRES_MAX;
            r.clamp = 1'b1;
        end
        r.centi_deg = t[bptc_pkg::TOUT_W-1:0];
        r.pascal    = p[bptc_pkg::POUT_W-1:0];
        return r;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // tracks calibration writes, predicts on each request, checks each response
    always @(posedge clk)
    begin : scoreboard
        reading_t want;
        if (rst_n)
        begin
            if (wr_en && wr_index <= bptc_pkg::IDX_C6)
                cal_model[wr_index] = wr_data;
            if (in_valid && in_ready)
                readings_due.push_back(compensate_reading(raw_pressure, raw_temperature));
            if (out_valid && out_ready)
            begin
                if (readings_due.size() == 0)
                begin
                    flag_error($sformatf("response with no request pending: T=%0d P=%0d C=%0d",
                                         temp_hundredths, pressure_pascal, clamped));
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (temp_hundredths !== want.centi_deg)
                        flag_error($sformatf("temp_hundredths got %0d want %0d",
                                             temp_hundredths, want.centi_deg));
                    if (pressure_pascal !== want.pascal)
                        flag_error($sformatf("pressure_pascal got %0d want %0d",
                                             pressure_pascal, want.pascal));
                    if (clamped !== want.clamp)
                        flag_error($sformatf("clamped got %b want %b", clamped, want.clamp));
                end
            end
        end
    end

    // response side: random stalls, or one long hold when asked
    initial
    begin : sink
        int n;
        forever
        begin
            @(posedge clk);
            if (sink_hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
                out_ready <= 1'b1;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 9);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [bptc_pkg::RAW_W-1:0] d1,
                               input logic [bptc_pkg::RAW_W-1:0] d2);
        int gap;
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        raw_pressure    <= d1;
        raw_temperature <= d2;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge clk);
        repeat (bptc_pkg::NSTAGE + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bptc_pkg::IDX_W-1:0] idx,
                             input logic [bptc_pkg::CAL_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
    endtask

    // only while idle; spare indexes get junk that must not land anywhere
    task automatic load_calibration(input logic [bptc_pkg::CAL_W-1:0] c1,
                                    input logic [bptc_pkg::CAL_W-1:0] c2,
                                    input logic [bptc_pkg::CAL_W-1:0] c3,
                                    input logic [bptc_pkg::CAL_W-1:0] c4,
                                    input logic [bptc_pkg::CAL_W-1:0] c5,
                                    input logic [bptc_pkg::CAL_W-1:0] c6);
        write_reg(bptc_pkg::IDX_C1, c1);
        write_reg(bptc_pkg::IDX_C2, c2);
        write_reg(bptc_pkg::IDX_C3, c3);
        write_reg(bptc_pkg::IDX_C4, c4);
        write_reg(bptc_pkg::IDX_C5, c5);
        write_reg(bptc_pkg::IDX_C6, c6);
        write_reg(IDX_SPARE_LO, bptc_pkg::CAL_W'($urandom()));
        write_reg(IDX_SPARE_HI, bptc_pkg::CAL_W'($urandom()));
        wr_en <= 1'b0;
    endtask

    task automatic load_typical();
        load_calibration(bptc_pkg::CAL_W'(TYP_C1), bptc_pkg::CAL_W'(TYP_C2),
                         bptc_pkg::CAL_W'(TYP_C3), bptc_pkg::CAL_W'(TYP_C4),
                         bptc_pkg::CAL_W'(TYP_C5), bptc_pkg::CAL_W'(TYP_C6));
    endtask

    task automatic test_reset_calibration();
        // all words still zero from reset
        send_sample('0, '0);
        send_sample('1, '1);
        send_sample(24'd6465444, 24'd8077636);
        send_sample(bptc_pkg::RAW_W'($urandom()), bptc_pkg::RAW_W'($urandom()));
        wait_idle();
    endtask

    task automatic test_directed_points();
        int base;
        base = TYP_C5 * 256;
        load_typical();
        send_sample(24'd6465444, 24'd8077636);
        send_sample(24'd6465444, bptc_pkg::RAW_W'(base));            // dT zero, 20.00 C
        send_sample(24'd6465444, bptc_pkg::RAW_W'(base - 1));        // floors to 19.99 C
        send_sample(24'd6465444, bptc_pkg::RAW_W'(base - 600000));
        send_sample(24'd6465444, bptc_pkg::RAW_W'(base - 1040000));  // either side of -15 C
        send_sample(24'd6465444, bptc_pkg::RAW_W'(base - 1045000));
        send_sample(24'd5000000, bptc_pkg::RAW_W'(base - 1500000));
        send_sample(24'd6465444, bptc_pkg::RAW_W'(base - 1900000));  // under -40 C
        send_sample(24'd6465444, bptc_pkg::RAW_W'(base + 1900000));
        send_sample(24'd6465444, bptc_pkg::RAW_W'(base + 1950000));  // over +85 C
        send_sample(24'd3800000, bptc_pkg::RAW_W'(base));
        send_sample(24'd7200000, bptc_pkg::RAW_W'(base));
        send_sample('0, bptc_pkg::RAW_W'(base));
        send_sample('1, bptc_pkg::RAW_W'(base));
        send_sample(24'd6465444, '0);
        send_sample(24'd6465444, '1);
        send_sample('0, '0);
        send_sample('1, '1);
        wait_idle();
    endtask

    task automatic test_calibration_extremes();
        load_calibration('1, '1, '1, '1, '1, '1);
        send_sample('0, '0);
        send_sample('0, '1);
        send_sample('1, '0);
        send_sample('1, '1);
        send_sample(24'd6465444, 24'd8077636);
        wait_idle();
        load_calibration('0, '0, '0, '0, '0, '0);
        send_sample('1, '1);
        send_sample(24'd6465444, 24'd8077636);
        wait_idle();
        load_calibration('1, '0, '1, '0, '1, '0);
        send_sample('1, 24'h800000);
        send_sample('1, '0);
        wait_idle();
        load_calibration('0, '1, '0, '1, '0, '1);
        send_sample('1, '1);
        send_sample(24'h7FFFFF, '0);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        int dt;
        load_typical();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        sink_hold   = 300;
        repeat (80)
        begin
            dt = int'($urandom_range(0, 4000000)) - 2000000;
            send_sample(bptc_pkg::RAW_W'($urandom_range(3800000, 7000000)),
                        bptc_pkg::RAW_W'(TYP_C5 * 256 + dt));
        end
        wait_idle();
    endtask

    task automatic test_typical_random();
        int c1, c2, c3, c4, c5, c6, dt, phase;
        for (phase = 0; phase < 4; phase++)
        begin
            c1 = TYP_C1 + int'($urandom_range(0, 8000)) - 4000;
            c2 = TYP_C2 + int'($urandom_range(0, 8000)) - 4000;
            c3 = TYP_C3 + int'($urandom_range(0, 8000)) - 4000;
            c4 = TYP_C4 + int'($urandom_range(0, 8000)) - 4000;
            c5 = TYP_C5 + int'($urandom_range(0, 8000)) - 4000;
            c6 = TYP_C6 + int'($urandom_range(0, 8000)) - 4000;
            load_calibration(bptc_pkg::CAL_W'(c1), bptc_pkg::CAL_W'(c2),
                             bptc_pkg::CAL_W'(c3), bptc_pkg::CAL_W'(c4),
                             bptc_pkg::CAL_W'(c5), bptc_pkg::CAL_W'(c6));
            src_gaps    = (phase != 1);
            sink_stalls = (phase != 2);
            repeat (220)
            begin
                dt = int'($urandom_range(0, 4000000)) - 2000000;
                send_sample(bptc_pkg::RAW_W'($urandom_range(3800000, 7000000)),
                            bptc_pkg::RAW_W'(c5 * 256 + dt));
            end
            wait_idle();
        end
    endtask

    task automatic test_noise_random();
        int phase;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        for (phase = 0; phase < 4; phase++)
        begin
            load_calibration(bptc_pkg::CAL_W'($urandom()), bptc_pkg::CAL_W'($urandom()),
                             bptc_pkg::CAL_W'($urandom()), bptc_pkg::CAL_W'($urandom()),
                             bptc_pkg::CAL_W'($urandom()), bptc_pkg::CAL_W'($urandom()));
            repeat (50)
                send_sample(bptc_pkg::RAW_W'($urandom()), bptc_pkg::RAW_W'($urandom()));
            wait_idle();
        end
    endtask

    task automatic test_steady_stream();
        int dt;
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        load_typical();
        repeat (100)
        begin
            dt = int'($urandom_range(0, 4000000)) - 2000000;
            send_sample(bptc_pkg::RAW_W'($urandom_range(3800000, 7000000)),
                        bptc_pkg::RAW_W'(TYP_C5 * 256 + dt));
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_calibration();
        test_directed_points();
        test_calibration_extremes();
        test_output_backpressure();
        test_typical_random();
        test_noise_random();
        test_steady_stream();
        if (mismatch_count == 0)
            $display("baro_pressure_temp_compensation_test: done, clean");
        else
            $display("baro_pressure_temp_compensation_test: done, errors");
        $finish;
    end

    initial
    begin
        #(2000000);
        $display("baro_pressure_temp_compensation_test: done, errors");
        $finish;
    end

endmodule
